// ===== rtl/gnds_pkg.sv =====
// package for the directional shade unit: state encodings, unit request/response
// structs, register indexes and defaults; no dependencies
package gnds_pkg;

  localparam int unsigned DefMaxWidth  = 4096;
  localparam int unsigned DefMaxHeight = 4096;

  // register indexes on the configuration port
  localparam logic [2:0] RegFrameWidth   = 3'd0;
  localparam logic [2:0] RegFrameHeight  = 3'd1;
  localparam logic [2:0] RegChannelCount = 3'd2;
  localparam logic [2:0] RegLightX       = 3'd3;
  localparam logic [2:0] RegLightY       = 3'd4;
  localparam logic [2:0] RegLightZ       = 3'd5;

  // operation codes of an input item
  localparam logic OpPixel = 1'b0;
  localparam logic OpDrain = 1'b1;

  // channel count codes
  localparam logic [2:0] ChanGray = 3'd1;
  localparam logic [2:0] ChanRgb  = 3'd3;

  // width of the squared-norm compare path
  localparam int unsigned LimW = 54;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_CENTER,
    ST_RD_NEIGH,
    ST_START,
    ST_WAIT,
    ST_EMIT
  } gnds_state_e;

  typedef enum logic [2:0] {
    U_IDLE,
    U_MUL,
    U_SUM,
    U_SQ,
    U_ITER,
    U_DONE
  } gnds_ustate_e;

  typedef struct packed {
    logic               start;
    logic signed [8:0]  dx;
    logic signed [8:0]  dy;
  } gnds_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] inten;
  } gnds_rsp_t;

endpackage

// ===== rtl/gradient_normal_directional_shade_unit.sv =====
// top level of the directional shade unit: line stores, sequencer, output register
// depends on gnds_pkg and gnds_inten
//
// channel   dir  handshake            payload
// in        in   in_valid_i/ready_o   operation_i chan0_i chan1_i chan2_i
// out       out  out_valid_o/ready_i  out_red_o out_green_o out_blue_o frame_end_o
// config    in   psel/penable/pwrite  paddr pwdata prdata pready
//
// one item at a time, input ready only in idle: a first-row pixel goes straight to emit, a border
// pixel or drain reads the line stores and then emits, an interior pixel also starts the unit and
// waits for done, with the root search skipped when the light faces away from the normal
// drain with nothing pending gives no transfer
// line stores have no clearing pass; reset clears counters and registers only
// a full, stalled output register keeps the next result waiting in emit, input not ready
module gradient_normal_directional_shade_unit import gnds_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = DefMaxWidth,
  parameter int unsigned MAX_HEIGHT = DefMaxHeight
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        operation_i,
  input  logic [7:0]  chan0_i,
  input  logic [7:0]  chan1_i,
  input  logic [7:0]  chan2_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_red_o,
  output logic [7:0]  out_green_o,
  output logic [7:0]  out_blue_o,
  output logic        frame_end_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  // configuration registers
  logic [12:0]        fw_q, fh_q;
  logic [2:0]         cc_q;
  logic signed [15:0] lx_q, ly_q, lz_q;
  logic               cfg_wr, geom_wr;
  logic [2:0]         cfg_idx;

  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;

  gnds_state_e state_q, state_d;

  logic [AW-1:0] col_q;
  logic [RW-1:0] row_q;
  logic [WW-1:0] drain_q;

  logic          op_q, interior_q, has_res_q, fend_q;
  logic [23:0]   pix_q, center_q;
  logic [7:0]    top_q;
  logic [AW-1:0] cur_col_q;
  logic [15:0]   inten_q;

  logic        out_valid_q, fend_out_q;
  logic [7:0]  red_q, green_q, blue_q;

  // line stores
  logic [23:0]   prev_mem [MAX_WIDTH];
  logic [7:0]    old_mem  [MAX_WIDTH];
  logic [23:0]   prev_rd_q;
  logic [7:0]    old_rd_q;
  logic [AW-1:0] prev_raddr, old_raddr;

  gnds_req_t req;
  gnds_rsp_t rsp;

  logic          in_xfer, slot_free, emit_go;
  logic [AW-1:0] col_e;
  logic [RW-1:0] row_e;
  logic          wrap;
  logic [WW-1:0] dcl;
  logic [15:0]   border;
  logic [15:0]   sh_r, sh_g, sh_b;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];
  assign geom_wr = cfg_wr && (cfg_idx == RegFrameWidth || cfg_idx == RegFrameHeight);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= 13'd1;
      fh_q <= 13'd1;
      cc_q <= ChanRgb;
      lx_q <= 16'sd0;
      ly_q <= 16'sd0;
      lz_q <= 16'sd32767;
    end else if (cfg_wr) begin
      case (cfg_idx)
        RegFrameWidth:   fw_q <= pwdata[12:0];
        RegFrameHeight:  fh_q <= pwdata[12:0];
        RegChannelCount: cc_q <= pwdata[2:0];
        RegLightX:       lx_q <= pwdata[15:0];
        RegLightY:       ly_q <= pwdata[15:0];
        RegLightZ:       lz_q <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  // register read-back
  always_comb begin
    case (cfg_idx)
      RegFrameWidth:   prdata = {19'd0, fw_q};
      RegFrameHeight:  prdata = {19'd0, fh_q};
      RegChannelCount: prdata = {29'd0, cc_q};
      RegLightX:       prdata = {16'd0, lx_q};
      RegLightY:       prdata = {16'd0, ly_q};
      RegLightZ:       prdata = {16'd0, lz_q};
      default:         prdata = 32'd0;
    endcase
  end

  // clamped frame geometry
  always_comb begin
    if (fw_q == 13'd0)                    w_eff = WW'(1);
    else if (32'(fw_q) > 32'(MAX_WIDTH))  w_eff = WW'(MAX_WIDTH);
    else                                  w_eff = WW'(fw_q);
    if (fh_q == 13'd0)                    h_eff = HW'(1);
    else if (32'(fh_q) > 32'(MAX_HEIGHT)) h_eff = HW'(MAX_HEIGHT);
    else                                  h_eff = HW'(fh_q);
  end

  // item position with frame restart
  assign wrap   = (32'(col_q) >= 32'(w_eff)) || (32'(row_q) >= 32'(h_eff));
  assign col_e  = wrap ? '0 : col_q;
  assign row_e  = wrap ? '0 : row_q;
  assign dcl    = (drain_q > w_eff) ? w_eff : drain_q;
  assign border = (lz_q <= 16'sd0) ? 16'd0 : {lz_q[14:0], 1'b0};

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;
  assign emit_go    = !has_res_q || slot_free;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (operation_i == OpPixel) begin
            state_d = (32'(row_e) >= 32'd1) ? ST_RD_CENTER : ST_EMIT;
          end else if (drain_q != '0) begin
            state_d = ST_RD_CENTER;
          end
        end
      end
      ST_RD_CENTER: state_d = ST_RD_NEIGH;
      ST_RD_NEIGH:  state_d = (op_q == OpPixel && interior_q) ? ST_START : ST_EMIT;
      ST_START:     state_d = ST_WAIT;
      ST_WAIT:      if (rsp.done) state_d = ST_EMIT;
      ST_EMIT:      if (emit_go) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // read addresses and unit request
  always_comb begin
    prev_raddr = cur_col_q;
    old_raddr  = cur_col_q;
    if (state_q == ST_RD_NEIGH) begin
      prev_raddr = AW'(cur_col_q + 1'b1);
      old_raddr  = AW'(cur_col_q - 1'b1);
    end
    req.start = (state_q == ST_START);
    req.dx    = $signed({1'b0, old_rd_q}) - $signed({1'b0, prev_rd_q[7:0]});
    req.dy    = $signed({1'b0, top_q}) - $signed({1'b0, pix_q[7:0]});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // frame counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      drain_q <= '0;
    end else if (geom_wr) begin
      col_q   <= '0;
      row_q   <= '0;
      drain_q <= '0;
    end else if (in_xfer) begin
      if (operation_i == OpPixel) begin
        drain_q <= '0;
        if (32'(col_e) + 32'd1 >= 32'(w_eff)) begin
          col_q <= '0;
          if (32'(row_e) + 32'd1 >= 32'(h_eff)) begin
            row_q   <= '0;
            drain_q <= w_eff;
          end else begin
            row_q <= RW'(row_e + 1'b1);
          end
        end else begin
          col_q <= AW'(col_e + 1'b1);
        end
      end else if (drain_q != '0) begin
        drain_q <= dcl - 1'b1;
      end
    end
  end

  // item registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q      <= operation_i;
      pix_q     <= {chan2_i, chan1_i, chan0_i};
      if (operation_i == OpPixel) begin
        cur_col_q  <= col_e;
        has_res_q  <= (32'(row_e) >= 32'd1);
        interior_q <= (32'(row_e) >= 32'd2) && (col_e != '0) &&
                      (32'(col_e) + 32'd1 < 32'(w_eff));
        fend_q     <= 1'b0;
      end else begin
        cur_col_q  <= AW'(w_eff - dcl);
        has_res_q  <= 1'b1;
        interior_q <= 1'b0;
        fend_q     <= (dcl == WW'(1));
      end
    end
    if (state_q == ST_RD_NEIGH) begin
      center_q <= prev_rd_q;
      top_q    <= old_rd_q;
      inten_q  <= border;
    end
    if (state_q == ST_WAIT && rsp.done) begin
      inten_q <= rsp.inten;
    end
  end

  // line store access
  always_ff @(posedge clk_i) begin
    prev_rd_q <= prev_mem[prev_raddr];
    old_rd_q  <= old_mem[old_raddr];
    if (state_q == ST_EMIT && emit_go && op_q == OpPixel) begin
      prev_mem[cur_col_q] <= pix_q;
      if (has_res_q) begin
        old_mem[cur_col_q] <= center_q[7:0];
      end
    end
  end

  gnds_inten u_inten (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req),
    .light_x_i (lx_q),
    .light_y_i (ly_q),
    .light_z_i (lz_q),
    .rsp_o     (rsp)
  );

  // shading products
  assign sh_r = 16'((24'(center_q[7:0])   * 24'(inten_q)) >> 16);
  assign sh_g = 16'((24'(center_q[15:8])  * 24'(inten_q)) >> 16);
  assign sh_b = 16'((24'(center_q[23:16]) * 24'(inten_q)) >> 16);

  // output stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_EMIT && has_res_q && slot_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_EMIT && has_res_q && slot_free) begin
      fend_out_q <= fend_q;
      if (cc_q == ChanGray) begin
        red_q   <= sh_r[7:0];
        green_q <= sh_r[7:0];
        blue_q  <= sh_r[7:0];
      end else if (cc_q >= ChanRgb) begin
        red_q   <= sh_r[7:0];
        green_q <= sh_g[7:0];
        blue_q  <= sh_b[7:0];
      end else begin
        red_q   <= 8'd0;
        green_q <= 8'd0;
        blue_q  <= 8'd0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_red_o   = red_q;
  assign out_green_o = green_q;
  assign out_blue_o  = blue_q;
  assign frame_end_o = fend_out_q;

`ifndef SYNTHESIS
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.done |-> state_q == ST_WAIT) else $error("unit done outside wait");
  a_emit_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && has_res_q && !slot_free) |=> state_q == ST_EMIT)
    else $error("result lost on stall");
  a_drain_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(drain_q) <= 32'(MAX_WIDTH)) else $error("drain count out of range");
`endif

endmodule

// ===== rtl/gnds_inten.sv =====
// interior intensity unit: floor(2*(n.L)/|n|) saturated to 16 bits
// iterative bit-by-bit root search; depends on gnds_pkg
module gnds_inten import gnds_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gnds_req_t          req_i,
  input  logic signed [15:0] light_x_i,
  input  logic signed [15:0] light_y_i,
  input  logic signed [15:0] light_z_i,
  output gnds_rsp_t          rsp_o
);

  gnds_ustate_e state_q, state_d;

  logic signed [8:0]  dx_q, dy_q;
  logic signed [24:0] px_q, py_q;
  logic [16:0]        dxsq_q, dysq_q;
  logic signed [26:0] num_q;
  logic [17:0]        d_q;
  logic [LimW-1:0]    lim_q, t_q, a_q, b_q;
  logic [15:0]        m_q;
  logic [3:0]         k_q;
  logic [LimW-1:0]    cand;
  logic               take;
  logic [25:0]        num_u;
  logic [51:0]        num_sq;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      U_IDLE:  if (req_i.start) state_d = U_MUL;
      U_MUL:   state_d = U_SUM;
      U_SUM:   state_d = U_SQ;
      U_SQ:    state_d = (num_q <= 27'sd0) ? U_DONE : U_ITER;
      U_ITER:  if (k_q == 4'd0) state_d = U_DONE;
      U_DONE:  state_d = U_IDLE;
      default: state_d = U_IDLE;
    endcase
  end

  // candidate square times norm for the current bit
  assign cand   = t_q + a_q + b_q;
  assign take   = (cand <= lim_q);
  assign num_u  = num_q[25:0];
  assign num_sq = num_u * num_u;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      U_IDLE: begin
        dx_q <= req_i.dx;
        dy_q <= req_i.dy;
      end
      U_MUL: begin
        px_q   <= 25'(dx_q) * 25'(light_x_i);
        py_q   <= 25'(dy_q) * 25'(light_y_i);
        dxsq_q <= 17'($unsigned(18'(dx_q) * 18'(dx_q)));
        dysq_q <= 17'($unsigned(18'(dy_q) * 18'(dy_q)));
      end
      U_SUM: begin
        num_q <= 27'(px_q) + 27'(py_q) + (27'(light_z_i) <<< 8) - 27'(light_z_i);
        d_q   <= 18'(dxsq_q) + 18'(dysq_q) + 18'd65025;
      end
      U_SQ: begin
        lim_q <= {num_sq, 2'b00};
        t_q   <= '0;
        a_q   <= '0;
        b_q   <= LimW'(d_q) << 30;
        m_q   <= '0;
        k_q   <= 4'd15;
      end
      U_ITER: begin
        if (take) begin
          t_q <= cand;
          a_q <= (a_q + (b_q << 1)) >> 1;
        end else begin
          a_q <= a_q >> 1;
        end
        b_q <= b_q >> 2;
        m_q <= {m_q[14:0], take};
        k_q <= k_q - 4'd1;
      end
      default: begin
      end
    endcase
  end

  // outputs
  always_comb begin
    rsp_o.done  = (state_q == U_DONE);
    rsp_o.inten = (num_q <= 27'sd0) ? 16'd0 : m_q;
  end

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> state_q == U_IDLE) else $error("start while busy");
  a_done_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.done |=> !rsp_o.done) else $error("done held");
  a_iter_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == U_ITER && k_q == 4'd0) |=> rsp_o.done) else $error("no done after iterations");
`endif

endmodule
